FILE: sv/rational_arith_unit_top_macros.svh
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITH_UNIT_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RAU_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rau: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define RAU_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rau: next-cycle check failed");

`endif

FILE: sv/rau_pkg.sv
// ============================================================================
// rau_pkg
// Types and codes shared by the rational arithmetic unit.
// ============================================================================
package rau_pkg;

    typedef struct packed {
        logic done;
        logic ov;
    } unit_stat_t;

    localparam logic [3:0] FN_MAKE    = 4'd0;
    localparam logic [3:0] FN_ADD     = 4'd1;
    localparam logic [3:0] FN_ADD_INT = 4'd2;
    localparam logic [3:0] FN_MUL     = 4'd3;
    localparam logic [3:0] FN_MUL_INT = 4'd4;
    localparam logic [3:0] FN_POW     = 4'd5;
    localparam logic [3:0] FN_EQ      = 4'd6;
    localparam logic [3:0] FN_NE      = 4'd7;
    localparam logic [3:0] FN_LT      = 4'd8;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;

    typedef enum logic [5:0] {
        ST_IDLE, ST_CHECK, ST_WAIT, ST_GCD, ST_GCD_STEP,
        ST_MK0, ST_MK1, ST_MK2, ST_MK3,
        ST_AD0, ST_AD1, ST_AD2, ST_AD3, ST_AD4, ST_AD5, ST_AD6, ST_AD7,
        ST_AI0, ST_AI1, ST_MU0, ST_MU1, ST_MU2, ST_MI0, ST_MI1,
        ST_PW0, ST_PW1, ST_PW2, ST_PW3, ST_PW4, ST_PWEND,
        ST_LT0, ST_LT1, ST_LT2, ST_FIN, ST_OUT
    } state_t;

endpackage

FILE: sv/rau_mul.sv
// ============================================================================
// rau_mul
// Shift-add multiplier, one multiplier bit per cycle, with wrap and overflow.
// ============================================================================
module rau_mul #(
    parameter int W = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic                uns,
    input  logic [W-1:0]        op_a,
    input  logic [W-1:0]        op_b,
    output logic [W-1:0]        res,
    output logic [2*W-1:0]      mag,
    output logic                neg,
    output rau_pkg::unit_stat_t stat
);
    localparam int CW = $clog2(W);

    logic [2*W-1:0] acc_reg, acc_next;
    logic [W-1:0]   mb_reg, mb_next;
    logic           neg_reg, neg_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]   a_mag, b_mag;
    logic [W:0]     sum;
    logic [W:0]     hi;

    always_comb begin
        a_mag = (!uns && op_a[W-1]) ? -op_a : op_a;
        b_mag = (!uns && op_b[W-1]) ? -op_b : op_b;
        sum   = {1'b0, acc_reg[2*W-1:W]} + {1'b0, mb_reg};
        acc_next  = acc_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = {{W{1'b0}}, a_mag};
            mb_next   = b_mag;
            neg_next  = !uns && (op_a[W-1] != op_b[W-1]);
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            // add when the low bit is set, then shift the product right
            acc_next = acc_reg[0] ? {sum, acc_reg[W-1:1]} : {1'b0, acc_reg[2*W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W-1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_comb begin
        hi        = acc_reg[2*W-1:W-1];
        mag       = acc_reg;
        neg       = neg_reg;
        res       = neg_reg ? -acc_reg[W-1:0] : acc_reg[W-1:0];
        stat.done = done_reg;
        // limit is 2^(W-1) for a negative product, 2^(W-1)-1 otherwise
        stat.ov   = neg_reg ? ((hi > (W+1)'(1)) || (hi == (W+1)'(1) && |acc_reg[W-2:0]))
                            : (|hi);
    end

endmodule

FILE: sv/rau_div.sv
// ============================================================================
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module rau_div #(
    parameter int W = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [W-1:0]        dividend,
    input  logic [W-1:0]        divisor,
    output logic [W-1:0]        quo,
    output logic [W-1:0]        rem,
    output rau_pkg::unit_stat_t stat
);
    localparam int CW = $clog2(W);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  d_reg, d_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W:0]    sh;
    logic [W+1:0]  diff;
    logic          ge;

    always_comb begin
        sh   = {rem_reg, quo_reg[W-1]};
        diff = {1'b0, sh} - {2'b00, d_reg};
        ge   = !diff[W+1];
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        d_next    = d_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            d_next    = divisor;
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            // keep the difference only when it does not borrow
            rem_next = ge ? diff[W-1:0] : sh[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W-1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_comb begin
        quo       = quo_reg;
        rem       = rem_reg;
        stat.done = done_reg;
        stat.ov   = 1'b0;
    end

endmodule

FILE: sv/rational_arith_unit_top.sv
// ============================================================================
// rational_arith_unit_top
// Rational arithmetic on WORD_BITS-bit two's complement words.
//
// Input channel s_*: one request carries an operation code, two fractions, an
// integer operand and an exponent; it is taken when s_valid and s_ready are
// both high. s_ready is high only while the sequencer is idle: one request is
// worked on at a time. Result channel m_*: numerator, denominator, compare
// flag and error code, held in an output register until m_ready takes them.
// A stalled receiver holds the finished result; the unit still accepts the
// next request and only waits at the end of that one if the register is full.
// One shared shift-add multiplier and one restoring divider, each working one
// bit per cycle (W = WORD_BITS). Unused codes and zero denominators go straight
// to the output, eq and ne use no unit, lt and mul use two multiplies each,
// power up to 22 multiplies, and make and add first run the Euclid gcd loop,
// which takes at most about 1.44 W division steps.
// Reset clears the sequencer and the output valid; no state survives items.
// ============================================================================
`include "rational_arith_unit_top_macros.svh"

module rational_arith_unit_top #(
    parameter int WORD_BITS = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_func,
    input  logic signed [31:0] s_a_num,
    input  logic signed [31:0] s_a_den,
    input  logic signed [31:0] s_b_num,
    input  logic [30:0]        s_b_den,
    input  logic signed [31:0] s_int_operand,
    input  logic signed [6:0]  s_exponent,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_res_num,
    output logic signed [31:0] m_res_den,
    output logic               m_compare_true,
    output logic [1:0]         m_error_code
);
    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W;
    localparam logic [W-1:0] W_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] W_ONE = W'(1);

    // sequencer state
    rau_pkg::state_t state_reg, state_next;
    rau_pkg::state_t ret_reg, ret_next;
    rau_pkg::state_t gret_reg, gret_next;

    // captured request
    logic [W-1:0] an_reg, an_next, ad_reg, ad_next, bn_reg, bn_next;
    logic [W-1:0] bd_reg, bd_next, iv_reg, iv_next;
    logic [3:0]   func_reg, func_next;
    logic         eneg_reg, eneg_next;
    logic [6:0]   k_reg, k_next;

    // working registers
    logic [W-1:0] rn_reg, rn_next, rd_reg, rd_next;
    logic [W-1:0] x_reg, x_next, y_reg, y_next, g_reg, g_next;
    logic [W-1:0] fa_reg, fa_next, fb_reg, fb_next;
    logic [W-1:0] t_reg, t_next, base_reg, base_next;
    logic [6:0]   kk_reg, kk_next;
    logic         phase_reg, phase_next;
    logic         ov_reg, ov_next, cmp_reg, cmp_next;
    logic [1:0]   err_reg, err_next;
    logic signed [PW:0] lhs_reg, lhs_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_num_reg, m_num_next, m_den_reg, m_den_next;
    logic               m_cmp_reg, m_cmp_next;
    logic [1:0]         m_err_reg, m_err_next;

    // shared units
    logic                mul_start, mul_uns, mul_neg;
    logic [W-1:0]        mul_a, mul_b, mul_res;
    logic [PW-1:0]       mul_mag;
    rau_pkg::unit_stat_t mul_stat;
    logic                div_start;
    logic [W-1:0]        div_n, div_d, div_q, div_r;
    rau_pkg::unit_stat_t div_stat;
    logic                unit_done;

    // input conditioning
    logic signed [W-1:0] an_in, ad_in, bn_in, bd_in, iv_in;
    logic                in_ov;
    logic [6:0]          k_in;

    // helpers
    logic [W-1:0] an_mag, ad_mag, bd_mag, rn_mag, rd_mag;
    logic [W-1:0] sa_val, sb_val, q_rn, q_rd;
    logic         sa_ov, sb_ov;
    logic [W-1:0] sum_ai, sum_ad;
    logic         ov_ai, ov_ad;
    logic signed [PW:0] prod_s;
    logic         lt_cmp, flip;
    logic signed [31:0] rn_lo, rd_lo;
    logic         fits;
    logic         bad_func, uses_b, zero_den, out_free;

    rau_mul #(.W(W)) u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .uns(mul_uns),
        .op_a(mul_a), .op_b(mul_b), .res(mul_res), .mag(mul_mag),
        .neg(mul_neg), .stat(mul_stat)
    );

    rau_div #(.W(W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_n), .divisor(div_d), .quo(div_q), .rem(div_r),
        .stat(div_stat)
    );

    assign unit_done = mul_stat.done | div_stat.done;

    // Wrap the 32-bit fields to the word; flag any that do not fit.
    always_comb begin
        an_in = W'(s_a_num);
        ad_in = W'(s_a_den);
        bn_in = W'(s_b_num);
        bd_in = W'(s_b_den);
        iv_in = W'(s_int_operand);
        in_ov = (32'(an_in) != s_a_num) || (32'(ad_in) != s_a_den) ||
                (32'(bn_in) != s_b_num) || (32'(iv_in) != s_int_operand) ||
                (32'(bd_in) != {1'b0, s_b_den});
        k_in  = s_exponent[6] ? (~s_exponent + 7'd1) : s_exponent;
    end

    always_comb begin
        an_mag = an_reg[W-1] ? -an_reg : an_reg;
        ad_mag = ad_reg[W-1] ? -ad_reg : ad_reg;
        bd_mag = bd_reg[W-1] ? -bd_reg : bd_reg;
        rn_mag = rn_reg[W-1] ? -rn_reg : rn_reg;
        rd_mag = rd_reg[W-1] ? -rd_reg : rd_reg;
        // scale factors for add carry the sign of the other denominator
        sa_val = ad_reg[W-1] ? -fb_reg : fb_reg;
        sb_val = bd_reg[W-1] ? -fa_reg : fa_reg;
        sa_ov  = ad_reg[W-1] ? (fb_reg[W-1] && |fb_reg[W-2:0]) : fb_reg[W-1];
        sb_ov  = bd_reg[W-1] ? (fa_reg[W-1] && |fa_reg[W-2:0]) : fa_reg[W-1];
        q_rn   = rn_reg[W-1] ? -div_q : div_q;
        q_rd   = rd_reg[W-1] ? -div_q : div_q;
        sum_ai = mul_res + an_reg;
        ov_ai  = (mul_res[W-1] == an_reg[W-1]) && (sum_ai[W-1] != mul_res[W-1]);
        sum_ad = t_reg + mul_res;
        ov_ad  = (t_reg[W-1] == mul_res[W-1]) && (sum_ad[W-1] != t_reg[W-1]);
        prod_s = mul_neg ? -$signed({1'b0, mul_mag}) : $signed({1'b0, mul_mag});
        flip   = ad_reg[W-1] != bd_reg[W-1];
        lt_cmp = flip ? (lhs_reg > prod_s) : (lhs_reg < prod_s);
        rn_lo  = 32'(signed'(rn_reg));
        rd_lo  = 32'(signed'(rd_reg));
        fits   = (W'(rn_lo) == rn_reg) && (W'(rd_lo) == rd_reg);
        bad_func = func_reg > rau_pkg::FN_LT;
        uses_b   = func_reg inside {rau_pkg::FN_ADD, rau_pkg::FN_MUL, rau_pkg::FN_EQ,
                                    rau_pkg::FN_NE, rau_pkg::FN_LT};
        zero_den = (ad_reg == '0) || (uses_b && bd_reg == '0) ||
                   (func_reg == rau_pkg::FN_POW && eneg_reg && an_reg == '0);
        out_free = !m_valid_reg || m_ready;
    end

    // Next state. Action states start a unit and park in ST_WAIT with the
    // state to resume in; the Euclid loop returns to gret_reg.
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        gret_next  = gret_reg;
        unique case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (s_valid) state_next = rau_pkg::ST_CHECK;
            end
            rau_pkg::ST_CHECK: begin
                if (bad_func || zero_den) begin
                    state_next = rau_pkg::ST_OUT;
                end else begin
                    case (func_reg)
                        rau_pkg::FN_MAKE:    state_next = rau_pkg::ST_MK0;
                        rau_pkg::FN_ADD:     state_next = rau_pkg::ST_AD0;
                        rau_pkg::FN_ADD_INT: state_next = rau_pkg::ST_AI0;
                        rau_pkg::FN_MUL:     state_next = rau_pkg::ST_MU0;
                        rau_pkg::FN_MUL_INT: state_next = rau_pkg::ST_MI0;
                        rau_pkg::FN_POW:     state_next = rau_pkg::ST_PW0;
                        rau_pkg::FN_LT:      state_next = rau_pkg::ST_LT0;
                        default:             state_next = rau_pkg::ST_FIN;
                    endcase
                end
            end
            rau_pkg::ST_WAIT: begin
                if (unit_done) state_next = ret_reg;
            end
            rau_pkg::ST_GCD: begin
                if (y_reg == '0) begin
                    state_next = gret_reg;
                end else begin
                    state_next = rau_pkg::ST_WAIT;
                    ret_next   = rau_pkg::ST_GCD_STEP;
                end
            end
            rau_pkg::ST_GCD_STEP: state_next = rau_pkg::ST_GCD;
            rau_pkg::ST_MK0: begin
                state_next = rau_pkg::ST_GCD;
                gret_next  = rau_pkg::ST_MK1;
            end
            rau_pkg::ST_MK1: begin
                state_next = rau_pkg::ST_WAIT;
                ret_next   = rau_pkg::ST_MK2;
            end
            rau_pkg::ST_MK2: begin
                state_next = rau_pkg::ST_WAIT;
                ret_next   = rau_pkg::ST_MK3;
            end
            rau_pkg::ST_MK3: state_next = rau_pkg::ST_FIN;
            rau_pkg::ST_AD0: begin
                state_next = rau_pkg::ST_GCD;
                gret_next  = rau_pkg::ST_AD1;
            end
            rau_pkg::ST_AD1: begin
                state_next = rau_pkg::ST_WAIT;
                ret_next   = rau_pkg::ST_AD2;
            end
            rau_pkg::ST_AD2: begin
                state_next = rau_pkg::ST_WAIT;
                ret_next   = rau_pkg::ST_AD3;
            end
            rau_pkg::ST_AD3: begin
                state_next = rau_pkg::ST_WAIT;
                ret_next   = rau_pkg::ST_AD4;
            end
            rau_pkg::ST_AD4: state_next = rau_pkg::ST_AD5;
            rau_pkg::ST_AD5: begin
                state_next = rau_pkg::ST_WAIT;
                ret_next   = rau_pkg::ST_AD6;
            end
            rau_pkg::ST_AD6: begin
                state_next = rau_pkg::ST_WAIT;
                ret_next   = rau_pkg::ST_AD7;
            end
            rau_pkg::ST_AD7: state_next = rau_pkg::ST_FIN;
            rau_pkg::ST_AI0: begin
                state_next = rau_pkg::ST_WAIT;
                ret_next   = rau_pkg::ST_AI1;
            end
            rau_pkg::ST_AI1: state_next = rau_pkg::ST_FIN;
            rau_pkg::ST_MU0: begin
                state_next = rau_pkg::ST_WAIT;
                ret_next   = rau_pkg::ST_MU1;
            end
            rau_pkg::ST_MU1: begin
                state_next = rau_pkg::ST_WAIT;
                ret_next   = rau_pkg::ST_MU2;
            end
            rau_pkg::ST_MU2: state_next = rau_pkg::ST_FIN;
            rau_pkg::ST_MI0: begin
                state_next = rau_pkg::ST_WAIT;
                ret_next   = rau_pkg::ST_MI1;
            end
            rau_pkg::ST_MI1: state_next = rau_pkg::ST_FIN;
            rau_pkg::ST_PW0: state_next = rau_pkg::ST_PW1;
            rau_pkg::ST_PW1: begin
                if (kk_reg == '0) begin
                    state_next = rau_pkg::ST_PWEND;
                end else if (kk_reg[0]) begin
                    state_next = rau_pkg::ST_WAIT;
                    ret_next   = rau_pkg::ST_PW2;
                end else begin
                    state_next = rau_pkg::ST_PW3;
                end
            end
            rau_pkg::ST_PW2: state_next = rau_pkg::ST_PW3;
            rau_pkg::ST_PW3: begin
                if (kk_reg[6:1] != '0) begin
                    state_next = rau_pkg::ST_WAIT;
                    ret_next   = rau_pkg::ST_PW4;
                end else begin
                    state_next = rau_pkg::ST_PW1;
                end
            end
            rau_pkg::ST_PW4: state_next = rau_pkg::ST_PW1;
            rau_pkg::ST_PWEND: begin
                state_next = phase_reg ? rau_pkg::ST_FIN : rau_pkg::ST_PW1;
            end
            rau_pkg::ST_LT0: begin
                state_next = rau_pkg::ST_WAIT;
                ret_next   = rau_pkg::ST_LT1;
            end
            rau_pkg::ST_LT1: begin
                state_next = rau_pkg::ST_WAIT;
                ret_next   = rau_pkg::ST_LT2;
            end
            rau_pkg::ST_LT2: state_next = rau_pkg::ST_FIN;
            rau_pkg::ST_FIN: state_next = rau_pkg::ST_OUT;
            rau_pkg::ST_OUT: begin
                if (out_free) state_next = rau_pkg::ST_IDLE;
            end
            default: state_next = rau_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and unit operands.
    always_comb begin
        s_ready   = (state_reg == rau_pkg::ST_IDLE);
        mul_start = 1'b0;
        mul_uns   = 1'b0;
        mul_a     = an_reg;
        mul_b     = bn_reg;
        div_start = 1'b0;
        div_n     = x_reg;
        div_d     = y_reg;
        unique case (state_reg)
            rau_pkg::ST_GCD: div_start = (y_reg != '0);
            rau_pkg::ST_MK1: begin
                div_start = 1'b1;
                div_n     = rn_mag;
                div_d     = g_reg;
            end
            rau_pkg::ST_MK2: begin
                div_start = 1'b1;
                div_n     = rd_mag;
                div_d     = g_reg;
            end
            rau_pkg::ST_AD1: begin
                div_start = 1'b1;
                div_n     = ad_mag;
                div_d     = g_reg;
            end
            rau_pkg::ST_AD2: begin
                div_start = 1'b1;
                div_n     = bd_mag;
                div_d     = g_reg;
            end
            rau_pkg::ST_AD3: begin
                mul_start = 1'b1;
                mul_uns   = 1'b1;
                mul_a     = fa_reg;
                mul_b     = bd_mag;
            end
            rau_pkg::ST_AD5: begin
                mul_start = 1'b1;
                mul_b     = fb_reg;
            end
            rau_pkg::ST_AD6: begin
                mul_start = 1'b1;
                mul_a     = bn_reg;
                mul_b     = fa_reg;
            end
            rau_pkg::ST_AI0: begin
                mul_start = 1'b1;
                mul_a     = iv_reg;
                mul_b     = ad_reg;
            end
            rau_pkg::ST_MU0: mul_start = 1'b1;
            rau_pkg::ST_MU1: begin
                mul_start = 1'b1;
                mul_a     = ad_reg;
                mul_b     = bd_reg;
            end
            rau_pkg::ST_MI0: begin
                mul_start = 1'b1;
                mul_b     = iv_reg;
            end
            rau_pkg::ST_PW1: begin
                mul_start = (kk_reg != '0) && kk_reg[0];
                mul_a     = t_reg;
                mul_b     = base_reg;
            end
            rau_pkg::ST_PW3: begin
                mul_start = (kk_reg[6:1] != '0);
                mul_a     = base_reg;
                mul_b     = base_reg;
            end
            rau_pkg::ST_LT0: begin
                mul_start = 1'b1;
                mul_b     = bd_reg;
            end
            rau_pkg::ST_LT1: begin
                mul_start = 1'b1;
                mul_a     = bn_reg;
                mul_b     = ad_reg;
            end
            default: ;
        endcase
    end

    // Datapath next values.
    always_comb begin
        an_next = an_reg;  ad_next = ad_reg;  bn_next = bn_reg;
        bd_next = bd_reg;  iv_next = iv_reg;  func_next = func_reg;
        eneg_next = eneg_reg;  k_next = k_reg;
        rn_next = rn_reg;  rd_next = rd_reg;
        x_next = x_reg;  y_next = y_reg;  g_next = g_reg;
        fa_next = fa_reg;  fb_next = fb_reg;
        t_next = t_reg;  base_next = base_reg;  kk_next = kk_reg;
        phase_next = phase_reg;  ov_next = ov_reg;  cmp_next = cmp_reg;
        err_next = err_reg;  lhs_next = lhs_reg;
        case (state_reg)
            rau_pkg::ST_IDLE: begin
                if (s_valid) begin
                    an_next   = an_in;
                    ad_next   = ad_in;
                    bn_next   = bn_in;
                    bd_next   = bd_in;
                    iv_next   = iv_in;
                    func_next = s_func;
                    eneg_next = s_exponent[6];
                    k_next    = k_in;
                    ov_next   = in_ov;
                end
            end
            rau_pkg::ST_CHECK: begin
                rn_next  = '0;
                rd_next  = '0;
                cmp_next = 1'b0;
                err_next = rau_pkg::ERR_NONE;
                if (bad_func) begin
                    err_next = rau_pkg::ERR_NONE;
                end else if (zero_den) begin
                    err_next = rau_pkg::ERR_ZERO_DEN;
                end else if (func_reg == rau_pkg::FN_EQ) begin
                    cmp_next = (an_reg == bn_reg) && (ad_reg == bd_reg);
                end else if (func_reg == rau_pkg::FN_NE) begin
                    cmp_next = (an_reg != bn_reg) || (ad_reg != bd_reg);
                end
            end
            rau_pkg::ST_WAIT: begin
                // products of lt are exact and never overflow
                if (mul_stat.done && func_reg != rau_pkg::FN_LT)
                    ov_next = ov_reg | mul_stat.ov;
            end
            rau_pkg::ST_GCD: begin
                if (y_reg == '0) g_next = (x_reg == '0) ? W_ONE : x_reg;
            end
            rau_pkg::ST_GCD_STEP: begin
                x_next = y_reg;
                y_next = div_r;
            end
            rau_pkg::ST_MK0: begin
                // move the sign into the numerator
                if (ad_reg[W-1]) begin
                    rn_next = -an_reg;
                    rd_next = -ad_reg;
                    ov_next = ov_reg | (an_reg == W_MIN) | (ad_reg == W_MIN);
                end else begin
                    rn_next = an_reg;
                    rd_next = ad_reg;
                end
                x_next = an_mag;
                y_next = ad_mag;
            end
            rau_pkg::ST_MK2: rn_next = q_rn;
            rau_pkg::ST_MK3: rd_next = (rn_reg == '0) ? W_ONE : q_rd;
            rau_pkg::ST_AD0: begin
                x_next = ad_mag;
                y_next = bd_mag;
            end
            rau_pkg::ST_AD2: fa_next = div_q;
            rau_pkg::ST_AD3: fb_next = div_q;
            rau_pkg::ST_AD4: begin
                rd_next = mul_res;
                fb_next = sa_val;
                fa_next = sb_val;
                ov_next = ov_reg | sa_ov | sb_ov;
            end
            rau_pkg::ST_AD6: t_next = mul_res;
            rau_pkg::ST_AD7: begin
                rn_next = sum_ad;
                ov_next = ov_reg | ov_ad;
            end
            rau_pkg::ST_AI1: begin
                rn_next = sum_ai;
                rd_next = ad_reg;
                ov_next = ov_reg | ov_ai;
            end
            rau_pkg::ST_MU1: rn_next = mul_res;
            rau_pkg::ST_MU2: rd_next = mul_res;
            rau_pkg::ST_MI1: begin
                rn_next = mul_res;
                rd_next = ad_reg;
            end
            rau_pkg::ST_PW0: begin
                base_next  = eneg_reg ? ad_reg : an_reg;
                t_next     = W_ONE;
                kk_next    = k_reg;
                phase_next = 1'b0;
            end
            rau_pkg::ST_PW2: t_next = mul_res;
            rau_pkg::ST_PW3: kk_next = {1'b0, kk_reg[6:1]};
            rau_pkg::ST_PW4: base_next = mul_res;
            rau_pkg::ST_PWEND: begin
                if (!phase_reg) begin
                    rn_next    = t_reg;
                    phase_next = 1'b1;
                    base_next  = eneg_reg ? an_reg : ad_reg;
                    t_next     = W_ONE;
                    kk_next    = k_reg;
                end else begin
                    rd_next = t_reg;
                end
            end
            rau_pkg::ST_LT1: lhs_next = prod_s;
            rau_pkg::ST_LT2: cmp_next = lt_cmp;
            rau_pkg::ST_FIN: begin
                err_next = (ov_reg || !fits) ? rau_pkg::ERR_OVERFLOW : rau_pkg::ERR_NONE;
            end
            default: ;
        endcase
    end

    // Output register: load when free, drop valid once taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        m_num_next   = m_num_reg;
        m_den_next   = m_den_reg;
        m_cmp_next   = m_cmp_reg;
        m_err_next   = m_err_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (state_reg == rau_pkg::ST_OUT && out_free) begin
            m_valid_next = 1'b1;
            m_num_next   = rn_lo;
            m_den_next   = rd_lo;
            m_cmp_next   = cmp_reg;
            m_err_next   = err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        an_reg <= an_next;  ad_reg <= ad_next;  bn_reg <= bn_next;
        bd_reg <= bd_next;  iv_reg <= iv_next;  func_reg <= func_next;
        eneg_reg <= eneg_next;  k_reg <= k_next;
        rn_reg <= rn_next;  rd_reg <= rd_next;
        x_reg <= x_next;  y_reg <= y_next;  g_reg <= g_next;
        fa_reg <= fa_next;  fb_reg <= fb_next;
        t_reg <= t_next;  base_reg <= base_next;  kk_reg <= kk_next;
        phase_reg <= phase_next;  ov_reg <= ov_next;  cmp_reg <= cmp_next;
        err_reg <= err_next;  lhs_reg <= lhs_next;
        m_num_reg <= m_num_next;  m_den_reg <= m_den_next;
        m_cmp_reg <= m_cmp_next;  m_err_reg <= m_err_next;
        if (!aresetn) begin
            state_reg   <= rau_pkg::ST_IDLE;
            ret_reg     <= rau_pkg::ST_IDLE;
            gret_reg    <= rau_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            gret_reg    <= gret_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_res_num      = m_num_reg;
    assign m_res_den      = m_den_reg;
    assign m_compare_true = m_cmp_reg;
    assign m_error_code   = m_err_reg;

    `RAU_ASSERT_IMP(a_err_legal, aclk, aresetn, m_valid,
        m_error_code == rau_pkg::ERR_NONE || m_error_code == rau_pkg::ERR_ZERO_DEN ||
        m_error_code == rau_pkg::ERR_OVERFLOW)
    `RAU_ASSERT_IMP(a_zero_den_fields, aclk, aresetn,
        m_valid && m_error_code == rau_pkg::ERR_ZERO_DEN,
        m_res_num == 32'sd0 && m_res_den == 32'sd0 && !m_compare_true)
    `RAU_ASSERT_IMP(a_cmp_fields_zero, aclk, aresetn, m_valid && m_compare_true,
        m_res_num == 32'sd0 && m_res_den == 32'sd0)
    `RAU_ASSERT_NXT(a_accept_to_check, aclk, aresetn, s_valid && s_ready,
        state_reg == rau_pkg::ST_CHECK)

endmodule
